/* design/lsas_pkg.sv */
// lsas_pkg: shared types, register indexes and fixed-point tables for the LED strip shader.
// Holds the sine and exp tables and the interpolating lookup functions.
// No dependencies.
`default_nettype none

package lsas_pkg;

  typedef enum logic [1:0] {
    MODE_STEADY = 2'd0,
    MODE_BREATH = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_COUNT = 3'd1,
    REG_WHITE = 3'd2,
    REG_RED   = 3'd3,
    REG_GREEN = 3'd4,
    REG_BLUE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_e;

  typedef struct packed {
    logic [7:0] white;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // one frame as handed from front to back
  typedef struct packed {
    logic [6:0]         n;
    logic [17:0]        quo;   // floor(2^17 / n)
    logic [6:0]         rem;   // 2^17 mod n
    logic [16:0]        gain;  // Q1.16 scale for non-scanner modes
    logic signed [17:0] sine;  // Q1.16 scanner center
    logic               scan;
  } frame_t;

  // per-LED sideband through the back pipeline
  typedef struct packed {
    logic [5:0]  idx;
    logic        last;
    logic        scan;
    logic [16:0] gain;
  } beat_t;

  localparam logic [16:0] SIN_TAB [17] = '{
    17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25079, 17'd30893, 17'd36410,
    17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798, 17'd60547,
    17'd62714, 17'd64277, 17'd65220, 17'd65536
  };

  localparam logic [16:0] EXP_WHOLE [8] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60
  };

  localparam logic [16:0] EXP_FRAC [17] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51040, 17'd47947,
    17'd45042, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954,
    17'd30957, 17'd29081, 17'd27319, 17'd25666, 17'd24109
  };

  // q in 0..0x4000
  function automatic logic [16:0] quarter_sine(logic [14:0] q);
    logic [4:0]  k;
    logic [16:0] lo;
    logic [16:0] step;
    logic [22:0] prod;
    k    = {1'b0, q[13:10]};
    lo   = SIN_TAB[k];
    step = SIN_TAB[k + 5'd1] - lo;
    prod = step[12:0] * q[9:0];
    if (q[14]) begin
      quarter_sine = SIN_TAB[16];
    end else begin
      quarter_sine = lo + 17'(prod[22:10]);
    end
  endfunction

  function automatic logic signed [17:0] phase_sine(logic [15:0] p);
    logic [14:0] q;
    logic [16:0] s;
    q = p[14] ? (15'h4000 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    s = quarter_sine(q);
    phase_sine = p[15] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  // e^-(fr/65536), fr a Q0.16 fraction, result Q16
  function automatic logic [16:0] exp_frac_interp(logic [15:0] fr);
    logic [4:0]  j;
    logic [16:0] hi;
    logic [16:0] diff;
    logic [23:0] prod;
    j    = {1'b0, fr[15:12]};
    hi   = EXP_FRAC[j];
    diff = hi - EXP_FRAC[j + 5'd1];
    prod = diff[11:0] * fr[11:0];
    exp_frac_interp = hi - 17'(prod[23:12]);
  endfunction

endpackage

`default_nettype wire

/* design/lsas_front.sv */
// lsas_front: accepts a phase, latches the frame setup, derives sine and gain,
// and runs an 18-step restoring divide of 2^17 by the LED count.
// Depends on lsas_pkg.
`default_nettype none

module lsas_front #(
  parameter int PHASE_BITS = 16,
  parameter int MAX_LEDS   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  input  lsas_pkg::mode_e       mode_i,
  input  logic [6:0]            led_count_i,
  output logic                  busy_o,
  output logic                  push_o,
  input  logic                  full_i,
  output lsas_pkg::frame_t      frame_o
);
  import lsas_pkg::*;

  localparam int QuoBits = 18;

  front_state_e       state_q, state_d;
  logic [15:0]        p_in;
  logic [15:0]        p_q;
  logic [15:0]        sin_arg;
  mode_e              mode_q;
  logic [6:0]         n_in;
  logic [6:0]         n_q;
  logic [4:0]         cnt_q;
  logic [7:0]         rem_q;
  logic [7:0]         rem_sh;
  logic [QuoBits-1:0] quo_q;
  logic               ge;
  logic signed [17:0] sin_q;
  logic [17:0]        breath;
  logic               accept;
  logic               div_last;

  generate
    if (PHASE_BITS >= 16) begin : g_phase_shr
      assign p_in = phase_i[PHASE_BITS-1 -: 16];
    end else begin : g_phase_shl
      assign p_in = 16'(phase_i) << (16 - PHASE_BITS);
    end
  endgenerate

  always_comb begin
    if (led_count_i == '0) begin
      n_in = 7'd1;
    end else if (int'(led_count_i) > MAX_LEDS) begin
      n_in = 7'(MAX_LEDS);
    end else begin
      n_in = led_count_i;
    end
  end

  assign div_last = (cnt_q == 5'(QuoBits - 1));
  assign rem_sh   = {rem_q[6:0], (cnt_q == '0)};
  assign ge       = (rem_sh >= {1'b0, n_q});
  assign sin_arg  = (mode_q == MODE_BREATH) ? (p_q + 16'h4000) : p_q;
  assign breath   = 18'd65536 - 18'(sin_q);

  always_comb begin
    state_d = state_q;
    accept  = 1'b0;
    push_o  = 1'b0;
    busy_o  = 1'b1;
    case (state_q)
      FS_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          accept  = 1'b1;
          state_d = FS_DIV;
        end
      end
      FS_DIV: begin
        if (div_last) state_d = FS_PUSH;
      end
      FS_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q    <= p_in;
      mode_q <= mode_i;
      n_q    <= n_in;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (state_q == FS_DIV) begin
      cnt_q <= cnt_q + 5'd1;
      rem_q <= ge ? (rem_sh - {1'b0, n_q}) : rem_sh;
      quo_q <= {quo_q[QuoBits-2:0], ge};
      sin_q <= phase_sine(sin_arg);
    end
  end

  always_comb begin
    frame_o.n    = n_q;
    frame_o.quo  = quo_q;
    frame_o.rem  = rem_q[6:0];
    frame_o.sine = sin_q;
    frame_o.scan = (mode_q == MODE_SCAN);
    case (mode_q)
      MODE_STEADY: frame_o.gain = 17'd65536;
      MODE_BREATH: frame_o.gain = breath[17:1];
      default:     frame_o.gain = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/lsas_queue.sv */
// lsas_queue: two-entry frame queue between front and back, head always at slot 0.
// Depends on lsas_pkg.
`default_nettype none

module lsas_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsas_pkg::frame_t frame_i,
  input  logic             pop_i,
  output lsas_pkg::frame_t frame_o,
  output logic             empty_o,
  output logic             full_o
);
  import lsas_pkg::*;

  frame_t     slot0_q, slot1_q;
  logic [1:0] cnt_q, cnt_d;

  assign frame_o = slot0_q;
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (push_i && cnt_q == 2'd1) slot0_q <= frame_i;
      else slot0_q <= slot1_q;
      if (push_i && cnt_q == 2'd2) slot1_q <= frame_i;
    end else if (push_i) begin
      if (cnt_q == 2'd0) slot0_q <= frame_i;
      else slot1_q <= frame_i;
    end
  end

endmodule

`default_nettype wire

/* design/lsas_back.sv */
// lsas_back: walks the LEDs of the head frame, one per cycle, through a 7-stage
// pipeline (distance, square, scale, /9, exp fraction, exp whole, channel scale).
// Depends on lsas_pkg.
`default_nettype none

module lsas_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsas_pkg::frame_t frame_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  lsas_pkg::color_t color_i,
  output logic             valid_o,
  output logic [5:0]       led_index_o,
  output logic [7:0]       out_white_o,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic             last_led_o
);
  import lsas_pkg::*;

  localparam int          Stages  = 7;
  localparam logic [34:0] ExpCut  = 35'd1546188227;  // d^2 at which u reaches 8.0
  localparam logic [23:0] InvNine = 24'd7456541;     // ceil(2^26 / 9)

  logic               iss;
  logic               last;
  logic [6:0]         i_q;
  logic [16:0]        qacc_q;
  logic [6:0]         racc_q;
  logic [7:0]         rsum;
  logic [17:0]        qsum;
  logic [Stages-1:0]  vld_q;
  beat_t              side_q [Stages];
  beat_t              beat_d;
  logic signed [18:0] d_d, d_q;
  logic signed [37:0] sq;
  logic [34:0]        dd_q;
  logic [38:0]        scl;
  logic [22:0]        m_q;
  logic [46:0]        rcp;
  logic [18:0]        u_q;
  logic [16:0]        f_q;
  logic [2:0]         ni_q;
  logic               z3_q, z4_q, z5_q;
  logic [33:0]        ep;
  logic [16:0]        g_q;
  logic [24:0]        pw, pr, pg, pb;
  logic [7:0]         w_q, r_q, gr_q, b_q;

  assign iss   = !empty_i;
  assign last  = (i_q == frame_i.n - 7'd1);
  assign pop_o = iss && last;
  assign rsum  = {1'b0, racc_q} + {1'b0, frame_i.rem};
  assign qsum  = {1'b0, qacc_q} + frame_i.quo;

  // x_i = floor(2^17 * i / n) tracked as quotient plus remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      qacc_q <= '0;
      racc_q <= '0;
    end else if (iss) begin
      if (last) begin
        i_q    <= '0;
        qacc_q <= '0;
        racc_q <= '0;
      end else begin
        i_q <= i_q + 7'd1;
        if (rsum >= {1'b0, frame_i.n}) begin
          racc_q <= 7'(rsum - {1'b0, frame_i.n});
          qacc_q <= 17'(qsum + 18'd1);
        end else begin
          racc_q <= rsum[6:0];
          qacc_q <= qsum[16:0];
        end
      end
    end
  end

  always_comb begin
    d_d = $signed({2'b00, qacc_q}) - 19'sd65536 - $signed({frame_i.sine[17], frame_i.sine});
    beat_d.idx  = i_q[5:0];
    beat_d.last = last;
    beat_d.scan = frame_i.scan;
    beat_d.gain = frame_i.gain;
  end

  assign sq  = d_q * d_q;
  assign scl = 39'(dd_q[30:0]) * 39'd200;
  assign rcp = 47'(m_q) * 47'(InvNine);
  assign ep  = EXP_WHOLE[ni_q] * f_q;
  assign pw  = color_i.white * g_q;
  assign pr  = color_i.red * g_q;
  assign pg  = color_i.green * g_q;
  assign pb  = color_i.blue * g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], iss};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= beat_d;
    for (int k = 1; k < Stages; k++) begin
      side_q[k] <= side_q[k-1];
    end
    d_q  <= d_d;
    dd_q <= sq[34:0];
    z3_q <= (dd_q >= ExpCut);
    m_q  <= scl[38:16];
    z4_q <= z3_q;
    u_q  <= rcp[44:26];
    z5_q <= z4_q;
    ni_q <= u_q[18:16];
    f_q  <= exp_frac_interp(u_q[15:0]);
    if (side_q[4].scan) begin
      g_q <= z5_q ? '0 : ep[32:16];
    end else begin
      g_q <= side_q[4].gain;
    end
    w_q  <= pw[23:16];
    r_q  <= pr[23:16];
    gr_q <= pg[23:16];
    b_q  <= pb[23:16];
  end

  assign valid_o     = vld_q[Stages-1];
  assign led_index_o = side_q[Stages-1].idx;
  assign last_led_o  = side_q[Stages-1].last;
  assign out_white_o = w_q;
  assign out_red_o   = r_q;
  assign out_green_o = gr_q;
  assign out_blue_o  = b_q;

endmodule

`default_nettype wire

/* design/led_strip_animation_shader.sv */
// led_strip_animation_shader: top level; config registers, front, frame queue and back.
// Depends on lsas_pkg, lsas_front, lsas_queue, lsas_back.
//
//   channel | signals                                         | handshake
//   --------+-------------------------------------------------+----------------------------
//   phase   | phase_i                                         | start_i & !busy_o
//   config  | cfg_index_i, cfg_data_i                         | cfg_valid_i & cfg_ready_o
//   result  | led_index_o, out_*_o, last_led_o                | valid_o strobe, one cycle
//
// The front takes a phase, runs 18 quotient steps of the LED-count divide, then hands
// the frame off, waiting while the queue is full, and takes no new phase till then; the
// back emits one LED per cycle while a frame is queued, through its pipeline registers.
// The two-entry queue lets the front work on the next frame while the back streams.
// Reset is asynchronous, active low; registers come up as mode off, 21 LEDs, black.
// Results cannot be stalled; busy_o is the only back-pressure.
`default_nettype none

module led_strip_animation_shader #(
  parameter int MAX_LEDS   = 64,
  parameter int PHASE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [PHASE_BITS-1:0] phase_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  output logic                  valid_o,
  output logic [5:0]            led_index_o,
  output logic [7:0]            out_white_o,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic                  last_led_o
);
  import lsas_pkg::*;

  mode_e      mode_q;
  logic [6:0] count_q;
  color_t     color_q;
  frame_t     front_frame;
  frame_t     head_frame;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      count_q <= 7'd21;
      color_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_MODE:  mode_q        <= mode_e'(cfg_data_i[1:0]);
        REG_COUNT: count_q       <= cfg_data_i[6:0];
        REG_WHITE: color_q.white <= cfg_data_i;
        REG_RED:   color_q.red   <= cfg_data_i;
        REG_GREEN: color_q.green <= cfg_data_i;
        REG_BLUE:  color_q.blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsas_front #(
    .PHASE_BITS(PHASE_BITS),
    .MAX_LEDS  (MAX_LEDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .phase_i    (phase_i),
    .mode_i     (mode_q),
    .led_count_i(count_q),
    .busy_o     (busy_o),
    .push_o     (push),
    .full_i     (q_full),
    .frame_o    (front_frame)
  );

  lsas_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .frame_i(front_frame),
    .pop_i  (pop),
    .frame_o(head_frame),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  lsas_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .frame_i    (head_frame),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .color_i    (color_q),
    .valid_o    (valid_o),
    .led_index_o(led_index_o),
    .out_white_o(out_white_o),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .last_led_o (last_led_o)
  );

endmodule

`default_nettype wire

/* test/led_strip_animation_shader_tb.sv */
`timescale 1ns / 1ps
// led_strip_animation_shader_tb: self-checking bench for the LED strip shader, directed table
// then randomized phases and register settings, each LED beat checked against a local predictor.
// Depends on lsas_pkg and led_strip_animation_shader.

module led_strip_animation_shader_tb;
  import lsas_pkg::*;

  localparam int          SETTLE_CYCLES = 40;
  localparam int          RANDOM_ROUNDS = 8;
  localparam int          ROUND_FRAMES  = 11;
  localparam logic [2:0]  IDX_SPARE_LO  = 3'd6;
  localparam logic [2:0]  IDX_SPARE_HI  = 3'd7;

  localparam int SINE_PTS [17] = '{
    0, 6424, 12785, 19024, 25079, 30893, 36410, 41576, 46341,
    50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536
  };
  localparam int unsigned EXP_UNIT [8] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60
  };
  localparam int unsigned EXP_STEP [17] = '{
    65536, 61565, 57835, 54331, 51040, 47947, 45042, 42313, 39750,
    37341, 35079, 32954, 30957, 29081, 27319, 25666, 24109
  };

  typedef struct packed {
    logic [5:0] idx;
    color_t     rgbw;
    logic       last;
  } led_beat_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [7:0]  data;
    logic [15:0] phase;
    logic        typed;
    logic [6:0]  n_leds;
    color_t      color;
  } stim_row_t;

  localparam color_t BLACK = '0;
  localparam color_t BASE  = '{white: 8'hFF, red: 8'h80, green: 8'h01, blue: 8'hAA};

  localparam stim_row_t PLAN [40] = '{
    '{1'b0, '0, 8'h00, 16'h0000, 1'b1, 7'd21, BLACK},
    '{1'b1, REG_MODE, {6'h00, MODE_STEADY}, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_WHITE, 8'hFF, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_RED, 8'h80, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_GREEN, 8'h01, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_BLUE, 8'hAA, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_COUNT, 8'd64, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'hFFFF, 1'b1, 7'd64, BASE},
    '{1'b1, REG_COUNT, 8'd0, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h1234, 1'b1, 7'd1, BASE},
    '{1'b1, REG_COUNT, 8'hFF, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h0000, 1'b1, 7'd64, BASE},
    '{1'b1, REG_COUNT, 8'h80, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, IDX_SPARE_LO, 8'h55, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, IDX_SPARE_HI, 8'hAA, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h8001, 1'b1, 7'd1, BASE},
    '{1'b1, REG_MODE, {6'h00, MODE_BREATH}, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_COUNT, 8'd8, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h0000, 1'b1, 7'd8, BLACK},
    '{1'b0, '0, 8'h00, 16'h8000, 1'b1, 7'd8, BASE},
    '{1'b0, '0, 8'h00, 16'h4000, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'hFFFF, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h2AAA, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_MODE, {6'h00, MODE_SCAN}, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_COUNT, 8'd21, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h0000, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h4000, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h8000, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'hC000, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h5555, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_COUNT, 8'd64, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'hFFFF, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_COUNT, 8'd1, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h3FFF, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_MODE, {6'h3F, MODE_OFF}, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_COUNT, 8'd64, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'hABCD, 1'b1, 7'd64, BLACK},
    '{1'b1, REG_COUNT, 8'h7F, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b1, REG_MODE, {6'h3F, MODE_STEADY}, 16'h0, 1'b0, 7'd0, BLACK},
    '{1'b0, '0, 8'h00, 16'h0F0F, 1'b1, 7'd64, BASE}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [15:0] phase_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        valid_o;
  logic [5:0]  led_index_o;
  logic [7:0]  out_white_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic        last_led_o;

  mode_e       shade_mode;
  logic [6:0]  shade_count;
  color_t      shade_color;
  led_beat_t   expected_leds [$];
  led_beat_t   want;
  int          mismatches;
  bit          frames_open;
  bit          gapless;

  led_strip_animation_shader u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .phase_i     (phase_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .led_index_o (led_index_o),
    .out_white_o (out_white_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .last_led_o  (last_led_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Q1.16 sine of a Q0.16 phase
  function automatic int wave_sine(logic [15:0] p);
    int q;
    int k;
    int f;
    int s;
    q = p[14] ? 'h4000 - p[13:0] : p[13:0];
    k = q >> 10;
    f = q & 'h3FF;
    if (k >= 16) s = SINE_PTS[16];
    else s = SINE_PTS[k] + (((SINE_PTS[k+1] - SINE_PTS[k]) * f) >> 10);
    return p[15] ? -s : s;
  endfunction

  // e^-u, u in Q16
  function automatic int unsigned gauss_gain(longint unsigned u);
    int unsigned n;
    int unsigned j;
    int unsigned r;
    int unsigned f;
    longint unsigned prod;
    if (u >= (64'd8 << 16)) return 0;
    n = u[18:16];
    j = u[15:12];
    r = u[11:0];
    f = EXP_STEP[j] - (((EXP_STEP[j] - EXP_STEP[j+1]) * r) >> 12);
    prod = longint'(EXP_UNIT[n]) * f;
    return int'(prod >> 16);
  endfunction

  function automatic logic [7:0] scale_chan(logic [7:0] c, int unsigned g);
    int unsigned prod;
    prod = c * g;
    return prod[23:16];
  endfunction

  function automatic void push_frame(logic [15:0] p, bit typed, int n_typed, color_t c_typed);
    int n;
    int s;
    int unsigned g;
    longint x;
    longint d;
    longint unsigned dd;
    led_beat_t b;
    n = shade_count;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    if (typed) n = n_typed;
    g = 0;
    s = 0;
    case (shade_mode)
      MODE_STEADY: g = 65536;
      MODE_BREATH: g = (65536 - wave_sine(16'(p + 16'h4000))) >> 1;
      MODE_SCAN:   s = wave_sine(p);
      default:     g = 0;
    endcase
    for (int i = 0; i < n; i++) begin
      if (shade_mode == MODE_SCAN) begin
        x  = -65536 + longint'((131072 * i) / n);
        d  = x - s;
        dd = d * d;
        g  = gauss_gain(dd * 200 / 589824);
      end
      b.idx  = i[5:0];
      b.last = (i == n - 1);
      if (typed) begin
        b.rgbw = c_typed;
      end else begin
        b.rgbw.white = scale_chan(shade_color.white, g);
        b.rgbw.red   = scale_chan(shade_color.red, g);
        b.rgbw.green = scale_chan(shade_color.green, g);
        b.rgbw.blue  = scale_chan(shade_color.blue, g);
      end
      expected_leds.push_back(b);
    end
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [7:0] d);
    case (idx)
      REG_MODE:  shade_mode = mode_e'(d[1:0]);
      REG_COUNT: shade_count = d[6:0];
      REG_WHITE: shade_color.white = d;
      REG_RED:   shade_color.red = d;
      REG_GREEN: shade_color.green = d;
      REG_BLUE:  shade_color.blue = d;
      default: ;
    endcase
  endfunction

  task automatic send_phase(logic [15:0] p, bit typed, int n_typed, color_t c_typed);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 18);
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    phase_i <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    push_frame(p, typed, n_typed, c_typed);
    frames_open = 1'b1;
  endtask

  // quiesce before touching registers
  task automatic settle_frames();
    if (frames_open) begin
      if (start_i) start_i <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      frames_open = 1'b0;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] d);
    settle_frames();
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, d);
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      3:       return 8'($urandom_range(48, 64));
      default: return 8'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [15:0] pick_phase();
    logic [1:0] quad;
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 65535));
    quad = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       return {quad, 14'h0000};
      1:       return {quad, 14'h0001};
      2:       return {quad, 14'h03FF};
      default: return {quad, 14'h3FFF};
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_leds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected led beat: idx %0d wrgb %h%h%h%h last %b", $realtime,
                   led_index_o, out_white_o, out_red_o, out_green_o, out_blue_o, last_led_o);
      end else begin
        want = expected_leds.pop_front();
        if (led_index_o !== want.idx || out_white_o !== want.rgbw.white ||
            out_red_o !== want.rgbw.red || out_green_o !== want.rgbw.green ||
            out_blue_o !== want.rgbw.blue || last_led_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch exp idx %0d wrgb %h last %b got idx %0d wrgb %h%h%h%h last %b",
                     $realtime, want.idx, want.rgbw, want.last, led_index_o,
                     out_white_o, out_red_o, out_green_o, out_blue_o, last_led_o);
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    phase_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    frames_open = 1'b0;
    gapless     = 1'b0;
    shade_mode  = MODE_OFF;
    shade_count = 7'd21;
    shade_color = BLACK;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[r]) begin
      if (PLAN[r].is_cfg) write_reg(PLAN[r].idx, PLAN[r].data);
      else send_phase(PLAN[r].phase, PLAN[r].typed, PLAN[r].n_leds, PLAN[r].color);
    end

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      if ($urandom_range(0, 3) != 0) write_reg(REG_MODE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) write_reg(REG_COUNT, pick_count());
      if ($urandom_range(0, 1) != 0) write_reg(REG_WHITE, pick_color());
      if ($urandom_range(0, 1) != 0) write_reg(REG_RED, pick_color());
      if ($urandom_range(0, 1) != 0) write_reg(REG_GREEN, pick_color());
      if ($urandom_range(0, 1) != 0) write_reg(REG_BLUE, pick_color());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, 8'($urandom_range(0, 255)));
      gapless = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ROUND_FRAMES; k++) send_phase(pick_phase(), 1'b0, 0, BLACK);
    end

    frames_open = 1'b1;
    settle_frames();
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (mismatches == 0 && expected_leds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
